// ===== hdl/mbsd_pkg.sv =====
// Package with the types, byte codes and length decode shared by the MIDI byte stream decoder.
package mbsd_pkg;

    typedef logic [7:0] midi_byte_t;
    typedef logic [1:0] msg_len_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_MSG  = 2'd1,
        KIND_BAD  = 2'd2
    } result_kind_t;

    localparam midi_byte_t REALTIME_MIN = 8'hF8;
    localparam midi_byte_t SYSEX_START  = 8'hF0;
    localparam midi_byte_t SYSEX_END    = 8'hF7;
    localparam midi_byte_t STATUS_BIT   = 8'h80;
    localparam midi_byte_t PROG_CHANGE  = 8'hC0;
    localparam midi_byte_t CHAN_PRESS   = 8'hD0;
    localparam midi_byte_t TIME_CODE    = 8'hF1;
    localparam midi_byte_t SONG_POS     = 8'hF2;
    localparam midi_byte_t SONG_SEL     = 8'hF3;
    localparam midi_byte_t TUNE_REQ     = 8'hF6;
    localparam midi_byte_t UPPER_NIBBLE = 8'hF0;

    // Total message length for a status byte, zero when the byte is not a
    // supported status.
    function automatic msg_len_t status_len(input midi_byte_t s);
        msg_len_t len;
        len = 2'd0;
        if ((s & STATUS_BIT) == 8'h00) begin
            len = 2'd0;
        end else if (s < SYSEX_START) begin
            if ((s & UPPER_NIBBLE) == PROG_CHANGE || (s & UPPER_NIBBLE) == CHAN_PRESS) begin
                len = 2'd2;
            end else begin
                len = 2'd3;
            end
        end else begin
            case (s)
                TIME_CODE, SONG_SEL: len = 2'd2;
                SONG_POS:            len = 2'd3;
                TUNE_REQ, SYSEX_END, 8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF: len = 2'd1;
                default:             len = 2'd0;
            endcase
        end
        return len;
    endfunction

endpackage

// ===== hdl/midi_byte_stream_decoder.sv =====
// MIDI byte stream decoder with running status, one result beat per input beat.
// Stages: input register, then result register; a beat waits in the input register while
// the receiver stalls. Throughput: one byte per cycle while the receiver keeps up; a
// short compare network decodes the input register into the result register while the
// parser state updates in the same cycle.
// Reset: synchronous, active-low aresetn empties both stages and clears the parser state.
module midi_byte_stream_decoder
    import mbsd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_result_kind,
    output logic [7:0] m_msg_status,
    output logic [6:0] m_data_first,
    output logic [6:0] m_data_second,
    output logic [1:0] m_msg_length
);

    // Pipeline occupancy and handshake control. The input stage hands its
    // beat to the result stage whenever the result stage is empty or is being
    // drained in the same cycle, so both sides can move every cycle.
    logic       in_valid_reg;
    midi_byte_t in_byte_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;

    // Parser state.
    midi_byte_t running_reg, running_next;
    midi_byte_t active_reg,  active_next;
    logic [1:0] seen_reg,    seen_next;
    logic [6:0] hold0_reg,   hold0_next;
    logic [6:0] hold1_reg,   hold1_next;
    logic       sysex_reg,   sysex_next;

    // Result of decoding the byte in the input register.
    result_kind_t kind_c;
    midi_byte_t   status_c;
    logic [6:0]   first_c;
    logic [6:0]   second_c;
    msg_len_t     len_c;

    // Result register.
    result_kind_t kind_reg;
    midi_byte_t   status_reg;
    logic [6:0]   first_reg;
    logic [6:0]   second_reg;
    msg_len_t     len_reg;

    always_comb begin
        midi_byte_t b;
        midi_byte_t act_v;
        logic [1:0] seen_v;
        logic [1:0] cnt_v;
        msg_len_t   len_v;
        logic [6:0] h0_v;
        logic [6:0] h1_v;

        b      = in_byte_reg;
        act_v  = active_reg;
        seen_v = seen_reg;
        cnt_v  = 2'd0;
        len_v  = 2'd0;
        h0_v   = hold0_reg;
        h1_v   = hold1_reg;

        running_next = running_reg;
        active_next  = active_reg;
        seen_next    = seen_reg;
        hold0_next   = hold0_reg;
        hold1_next   = hold1_reg;
        sysex_next   = sysex_reg;

        kind_c   = KIND_NONE;
        status_c = 8'h00;
        first_c  = 7'h00;
        second_c = 7'h00;
        len_c    = 2'd0;

        if (b >= REALTIME_MIN) begin
            // Realtime bytes pass straight through and leave the state alone.
            if (status_len(b) == 2'd0) begin
                kind_c = KIND_BAD;
            end else begin
                kind_c   = KIND_MSG;
                status_c = b;
                len_c    = 2'd1;
            end
        end else if (sysex_reg && b == SYSEX_END) begin
            // End of a system-exclusive block is reported as discarded.
            sysex_next = 1'b0;
            kind_c     = KIND_BAD;
        end else if (sysex_reg && !b[7]) begin
            // Data inside a system-exclusive block is swallowed.
            kind_c = KIND_NONE;
        end else if (b[7]) begin
            // Any other status byte closes an open sysex block first.
            sysex_next = 1'b0;
            if (b == SYSEX_START) begin
                running_next = 8'h00;
                active_next  = 8'h00;
                seen_next    = 2'd0;
                sysex_next   = 1'b1;
                kind_c       = KIND_BAD;
            end else begin
                len_v     = status_len(b);
                seen_next = 2'd0;
                if (len_v == 2'd0) begin
                    // Undefined status keeps the running status.
                    active_next = 8'h00;
                    kind_c      = KIND_BAD;
                end else begin
                    active_next  = b;
                    running_next = (b < SYSEX_START) ? b : 8'h00;
                    if (len_v == 2'd1) begin
                        active_next = 8'h00;
                        kind_c      = KIND_MSG;
                        status_c    = b;
                        len_c       = 2'd1;
                    end
                end
            end
        end else begin
            // Data byte: fall back on the running status when nothing is active.
            if (active_reg == 8'h00) begin
                act_v  = running_reg;
                seen_v = 2'd0;
            end
            len_v = status_len(act_v);
            if (len_v < 2'd2 || seen_v >= 2'd2) begin
                active_next = 8'h00;
                seen_next   = 2'd0;
                kind_c      = KIND_BAD;
            end else begin
                if (seen_v[0]) begin
                    h1_v = b[6:0];
                end else begin
                    h0_v = b[6:0];
                end
                hold0_next = h0_v;
                hold1_next = h1_v;
                cnt_v      = seen_v + 2'd1;
                if ((3'(cnt_v) + 3'd1) < 3'(len_v)) begin
                    active_next = act_v;
                    seen_next   = cnt_v;
                    kind_c      = KIND_NONE;
                end else begin
                    active_next = running_reg;
                    seen_next   = 2'd0;
                    kind_c      = KIND_MSG;
                    status_c    = act_v;
                    first_c     = h0_v;
                    second_c    = (len_v > 2'd2) ? h1_v : 7'h00;
                    len_c       = len_v;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= 8'h00;
            active_reg    <= 8'h00;
            seen_reg      <= 2'd0;
            hold0_reg     <= 7'h00;
            hold1_reg     <= 7'h00;
            sysex_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                running_reg <= running_next;
                active_reg  <= active_next;
                seen_reg    <= seen_next;
                hold0_reg   <= hold0_next;
                hold1_reg   <= hold1_next;
                sysex_reg   <= sysex_next;
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
        if (advance) begin
            kind_reg   <= kind_c;
            status_reg <= status_c;
            first_reg  <= first_c;
            second_reg <= second_c;
            len_reg    <= len_c;
        end
    end

    assign m_result_kind = kind_reg;
    assign m_msg_status  = status_reg;
    assign m_data_first  = first_reg;
    assign m_data_second = second_reg;
    assign m_msg_length  = len_reg;

    // Inside a sysex block neither a running nor an active status survives.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sysex_reg |-> (running_reg == 8'h00 && active_reg == 8'h00))
        else $error("sysex block open with a live status");

    // The data count is zero whenever no status is active, and never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (active_reg == 8'h00) |-> (seen_reg == 2'd0))
        else $error("data count held without an active status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg != 2'd2 && seen_reg != 2'd3)
        else $error("data count out of range");

    // A result beat that is not a message carries all-zero fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind != KIND_MSG) |->
        (m_msg_status == 8'h00 && m_data_first == 7'h00 &&
         m_data_second == 7'h00 && m_msg_length == 2'd0))
        else $error("non-message result carries payload");

endmodule

// ===== dv/tb_midi_byte_stream_decoder.sv =====
// Self-checking testbench for the MIDI byte stream decoder with running status.
`timescale 1ns / 1ps

module tb_midi_byte_stream_decoder
    import mbsd_pkg::*;
();

    // Byte codes that the package does not name but the stimulus and the
    // length decode need.
    localparam midi_byte_t RT_UNDEF_LO  = 8'hF9;
    localparam midi_byte_t RT_UNDEF_HI  = 8'hFD;
    localparam midi_byte_t SYS_UNDEF_LO = 8'hF4;
    localparam midi_byte_t SYS_UNDEF_HI = 8'hF5;
    localparam midi_byte_t CHAN_LAST    = 8'hEF;
    localparam midi_byte_t DATA_MAX     = 8'h7F;

    localparam int RANDOM_BEATS = 1000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 16;

    // One decoded result, laid out in port order so that the output ports
    // can be packed straight into it.
    typedef struct packed {
        result_kind_t  kind;
        midi_byte_t    status;
        logic [6:0]    first;
        logic [6:0]    second;
        msg_len_t      length;
    } midi_msg_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_result_kind;
    logic [7:0] m_msg_status;
    logic [6:0] m_data_first;
    logic [6:0] m_data_second;
    logic [1:0] m_msg_length;

    midi_byte_stream_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_msg_status  (m_msg_status),
        .m_data_first  (m_data_first),
        .m_data_second (m_data_second),
        .m_msg_length  (m_msg_length)
    );

    // 8 ns clock.
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Reset is released on a falling edge, once.
    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Parser mirror. This is the testbench's own copy of the decoder state;
    // it is advanced once per accepted input beat.
    // ------------------------------------------------------------------
    midi_byte_t mirror_running = 8'h00;
    midi_byte_t open_status    = 8'h00;   // status of the message being built
    logic [1:0] mirror_count   = 2'd0;
    logic [6:0] held_data [2]  = '{7'd0, 7'd0};
    logic       sysex_open     = 1'b0;

    // Total length of the message a status byte starts, zero for anything
    // that is not a supported status. Channel voice messages take the upper
    // nibble into account; program change and channel pressure carry a
    // single data byte.
    function automatic msg_len_t expected_length(input midi_byte_t s);
        if (!s[7]) begin
            return 2'd0;
        end
        if (s < SYSEX_START) begin
            if (s[7:4] == PROG_CHANGE[7:4] || s[7:4] == CHAN_PRESS[7:4]) begin
                return 2'd2;
            end
            return 2'd3;
        end
        if (s >= REALTIME_MIN) begin
            return (s == RT_UNDEF_LO || s == RT_UNDEF_HI) ? 2'd0 : 2'd1;
        end
        case (s)
            TIME_CODE, SONG_SEL: return 2'd2;
            SONG_POS:            return 2'd3;
            TUNE_REQ, SYSEX_END: return 2'd1;
            default:             return 2'd0;
        endcase
    endfunction

    // Advance the mirror by one byte and return the result beat the block
    // must produce for it. Fields other than the kind stay zero unless a
    // message completes.
    function automatic midi_msg_t decode_midi_byte(input midi_byte_t b);
        midi_msg_t r;
        msg_len_t  need;
        r = '0;
        r.kind = KIND_NONE;

        // Realtime bytes slip through anywhere without touching the state,
        // even in the middle of a system-exclusive block.
        if (b >= REALTIME_MIN) begin
            if (expected_length(b) == 2'd0) begin
                r.kind = KIND_BAD;
            end else begin
                r.kind   = KIND_MSG;
                r.status = b;
                r.length = 2'd1;
            end
            return r;
        end

        // Inside a sysex block data is swallowed; the end marker closes the
        // block as unsupported, and any other status closes it and is then
        // decoded as usual below.
        if (sysex_open) begin
            if (b == SYSEX_END) begin
                sysex_open = 1'b0;
                r.kind = KIND_BAD;
                return r;
            end
            if (!b[7]) begin
                return r;
            end
            sysex_open = 1'b0;
        end

        if (b[7]) begin
            if (b == SYSEX_START) begin
                mirror_running = 8'h00;
                open_status    = 8'h00;
                mirror_count   = 2'd0;
                sysex_open     = 1'b1;
                r.kind = KIND_BAD;
                return r;
            end
            need = expected_length(b);
            mirror_count = 2'd0;
            if (need == 2'd0) begin
                // Undefined status drops the message in progress but leaves
                // running status alone.
                open_status = 8'h00;
                r.kind = KIND_BAD;
                return r;
            end
            open_status    = b;
            mirror_running = (b < SYSEX_START) ? b : 8'h00;
            if (need != 2'd1) begin
                return r;
            end
            // One-byte system messages, including a stray end of sysex.
            open_status = 8'h00;
            r.kind   = KIND_MSG;
            r.status = b;
            r.length = 2'd1;
            return r;
        end

        // Data byte: fall back to running status when nothing is open.
        if (open_status == 8'h00) begin
            open_status  = mirror_running;
            mirror_count = 2'd0;
        end
        need = expected_length(open_status);
        if (need < 2'd2 || mirror_count >= 2'd2) begin
            open_status  = 8'h00;
            mirror_count = 2'd0;
            r.kind = KIND_BAD;
            return r;
        end
        held_data[mirror_count[0]] = b[6:0];
        mirror_count = mirror_count + 2'd1;
        if (int'(mirror_count) + 1 < int'(need)) begin
            return r;
        end
        r.kind   = KIND_MSG;
        r.status = open_status;
        r.first  = held_data[0];
        r.second = (need > 2'd2) ? held_data[1] : 7'd0;
        r.length = need;
        mirror_count = 2'd0;
        open_status  = mirror_running;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus store and scoreboard state.
    // ------------------------------------------------------------------
    midi_byte_t pending_bytes [$];
    midi_msg_t  expected_msgs [$];
    int         stream_length = 0;
    int         bytes_taken   = 0;
    int         results_seen  = 0;
    int         msgs_seen     = 0;
    int         bad_seen      = 0;
    int         error_count   = 0;
    logic       in_beat_done  = 1'b0;
    logic       out_beat_done = 1'b0;

    // Push one byte, now and then preceded by a realtime byte so that
    // realtime traffic lands inside every kind of message and sysex block.
    task automatic queue_byte(input midi_byte_t b);
        if ($urandom_range(0, 15) == 0) begin
            pending_bytes.push_back(midi_byte_t'(REALTIME_MIN + $urandom_range(0, 7)));
        end
        pending_bytes.push_back(b);
    endtask

    function automatic midi_byte_t random_data();
        return midi_byte_t'($urandom_range(0, DATA_MAX));
    endfunction

    // Fill the stimulus before the clock runs. The directed opening walks
    // through the corner cases in order; the random part is mostly
    // well-formed traffic with random content, plus broken and noise bytes.
    initial begin
        midi_byte_t st;
        msg_len_t   need;
        int         pick;
        int         n;

        // Data with nothing open, both undefined realtime bytes, a note on
        // with extreme data, a running-status repeat, a two-byte channel
        // message, a sysex block with realtime inside and its end marker, a
        // sysex block cut short by a status byte, an undefined status, a
        // time code, a tune request followed by orphan data, a lone end of
        // sysex, a song position and the other undefined status.
        pending_bytes = '{8'h00, RT_UNDEF_LO, RT_UNDEF_HI,
                          8'h90, DATA_MAX, 8'h00, 8'h01, DATA_MAX,
                          8'hDF, DATA_MAX,
                          SYSEX_START, 8'h12, 8'hFF, SYSEX_END,
                          SYSEX_START, 8'hB0, SYS_UNDEF_LO,
                          TIME_CODE, DATA_MAX, TUNE_REQ, 8'h40, SYSEX_END,
                          SONG_POS, 8'h00, DATA_MAX, SYS_UNDEF_HI};

        while (pending_bytes.size() < RANDOM_BEATS + 26) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // Channel message followed by up to three running-status repeats.
                st   = midi_byte_t'($urandom_range(STATUS_BIT, CHAN_LAST));
                need = expected_length(st);
                queue_byte(st);
                n = $urandom_range(1, 4);
                repeat (n) begin
                    repeat (need - 1) queue_byte(random_data());
                end
            end else if (pick < 60) begin
                case ($urandom_range(0, 3))
                    0:       st = TIME_CODE;
                    1:       st = SONG_POS;
                    2:       st = SONG_SEL;
                    default: st = TUNE_REQ;
                endcase
                queue_byte(st);
                repeat (expected_length(st) - 1) queue_byte(random_data());
            end else if (pick < 70) begin
                // Sysex block, usually closed by its end marker, sometimes
                // broken off by another status byte.
                queue_byte(SYSEX_START);
                n = $urandom_range(0, 6);
                repeat (n) queue_byte(random_data());
                if ($urandom_range(0, 3) == 0) begin
                    queue_byte(midi_byte_t'($urandom_range(STATUS_BIT, TUNE_REQ)));
                end else begin
                    queue_byte(SYSEX_END);
                end
            end else if (pick < 80) begin
                pending_bytes.push_back(midi_byte_t'(REALTIME_MIN + $urandom_range(0, 7)));
            end else if (pick < 90) begin
                // Truncated channel message: it stays open until a later byte
                // interrupts or completes it.
                st   = midi_byte_t'($urandom_range(STATUS_BIT, CHAN_LAST));
                need = expected_length(st);
                queue_byte(st);
                n = $urandom_range(0, need - 2);
                repeat (n) queue_byte(random_data());
            end else begin
                n = $urandom_range(1, 3);
                repeat (n) pending_bytes.push_back(midi_byte_t'($urandom_range(0, 255)));
            end
        end
        stream_length = pending_bytes.size();
    end

    // ------------------------------------------------------------------
    // Driver: presents one byte per beat on the falling edge. After each
    // accepted beat it holds valid low for a drawn number of cycles, except
    // in burst stretches where bytes follow back to back.
    // ------------------------------------------------------------------
    int   send_gap   = 0;
    logic send_burst = 1'b0;

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_beat_done)) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                s_in_byte <= pending_bytes.pop_front();
                s_valid   <= 1'b1;
                if ($urandom_range(0, 39) == 0) begin
                    send_burst = !send_burst;
                end
                send_gap = send_burst ? 0 : $urandom_range(0, 9);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: after each accepted result beat, ready drops
    // for a drawn number of cycles, with burst stretches of no stalls.
    // ------------------------------------------------------------------
    int   recv_stall = 0;
    logic recv_burst = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_beat_done) begin
                if ($urandom_range(0, 39) == 0) begin
                    recv_burst = !recv_burst;
                end
                recv_stall = recv_burst ? 0 : $urandom_range(0, 9);
            end
            if (recv_stall > 0) begin
                recv_stall = recv_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard on the rising edge. Each accepted input beat
    // queues its expected result first, so even a block that answered in
    // the same cycle would be checked in order; each accepted result beat
    // is then compared with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        midi_msg_t got;
        midi_msg_t want;
        in_beat_done  <= aresetn && s_valid && s_ready;
        out_beat_done <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_msgs.push_back(decode_midi_byte(s_in_byte));
            bytes_taken = bytes_taken + 1;
        end
        if (aresetn && m_valid && m_ready) begin
            got = {m_result_kind, m_msg_status, m_data_first, m_data_second, m_msg_length};
            results_seen = results_seen + 1;
            if (expected_msgs.size() == 0) begin
                error_count = error_count + 1;
                if (error_count <= MAX_REPORTS) begin
                    $display("ERROR: result beat with nothing expected: kind=%0d status=%h",
                             got.kind, got.status);
                end
            end else begin
                want = expected_msgs.pop_front();
                if (got !== want) begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS) begin
                        $display({"ERROR: result %0d expected kind=%0d status=%h",
                                  " d1=%h d2=%h len=%0d"},
                                 results_seen, want.kind, want.status, want.first,
                                 want.second, want.length);
                        $display("       got      kind=%0d status=%h d1=%h d2=%h len=%0d",
                                 got.kind, got.status, got.first, got.second, got.length);
                    end
                end
                if (want.kind == KIND_MSG) begin
                    msgs_seen = msgs_seen + 1;
                end else if (want.kind == KIND_BAD) begin
                    bad_seen = bad_seen + 1;
                end
            end
        end
    end

    // End of run: all bytes in, all results out, then a short drain so a
    // stray extra beat would still be caught.
    initial begin
        @(posedge aresetn);
        while (stream_length == 0 || bytes_taken < stream_length || expected_msgs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        error_count = error_count + expected_msgs.size();
        $display("Decoded %0d bytes into %0d result beats:",
                 bytes_taken, results_seen);
        $display("%0d complete messages and %0d unsupported or discarded bytes.",
                 msgs_seen, bad_seen);
        if (error_count > MAX_REPORTS) begin
            $display("%0d mismatches in total, only the first %0d were reported.",
                     error_count, MAX_REPORTS);
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timeout: %0d of %0d bytes taken, %0d results pending.",
                 bytes_taken, stream_length, expected_msgs.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
